// File: rtl/core/tlc_pkg.sv
`default_nettype none

package tlc_pkg;

    localparam int ADDR_W         = 32;

    localparam int L1_SETS        = 64;
    localparam int L1_WAYS        = 2;
    localparam int L1_BLOCK_BYTES = 32;
    localparam int L2_SETS        = 512;
    localparam int L2_WAYS        = 4;
    localparam int L2_BLOCK_BYTES = 64;

    localparam int L1_OFF_W  = $clog2(L1_BLOCK_BYTES);
    localparam int L1_SET_W  = $clog2(L1_SETS);
    localparam int L1_TAG_W  = ADDR_W - L1_OFF_W - L1_SET_W;
    localparam int L1_ROWS   = 2 * L1_SETS;
    localparam int L1_IDX_W  = L1_SET_W + 1;
    localparam int L1_WAY_W  = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;

    localparam int L2_OFF_W  = $clog2(L2_BLOCK_BYTES);
    localparam int L2_SET_W  = $clog2(L2_SETS);
    localparam int L2_TAG_W  = ADDR_W - L2_OFF_W - L2_SET_W;
    localparam int L2_LINE_W = L2_SET_W + L2_TAG_W;
    localparam int L2_WAY_W  = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;

    localparam int CLR_ROWS  = (L2_SETS > L1_ROWS) ? L2_SETS : L1_ROWS;
    localparam int CLR_W     = $clog2(CLR_ROWS + 1);

    localparam logic [1:0] OP_FETCH = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic [L1_WAYS-1:0][L1_TAG_W-1:0] tag;
        logic [L1_WAYS-1:0]               valid;
        logic [L1_WAYS-1:0]               dirty;
        logic [L1_WAYS-1:0][L1_WAY_W-1:0] rank;
    } l1_row_t;

    typedef struct packed {
        logic [L2_WAYS-1:0][L2_TAG_W-1:0] tag;
        logic [L2_WAYS-1:0]               valid;
        logic [L2_WAYS-1:0][L2_WAY_W-1:0] rank;
    } l2_row_t;

    typedef struct packed {
        logic                hit;
        logic                evict;
        logic [L1_TAG_W-1:0] vtag;
    } l1_res_t;

endpackage

`default_nettype wire

// File: rtl/core/tlc_l1.sv
`default_nettype none

module tlc_l1
    import tlc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [L1_IDX_W-1:0] rd_idx,
    input  wire logic [L1_TAG_W-1:0] tag,
    input  wire logic                set_dirty,
    input  wire logic                commit,
    input  wire logic                clr_en,
    input  wire logic [L1_IDX_W-1:0] clr_idx,
    output l1_res_t                  res
);

    l1_row_t mem [L1_ROWS];
    l1_row_t row_reg;
    logic [L1_IDX_W-1:0] idx_reg;

    l1_row_t new_row;
    l1_row_t clr_row;
    logic [L1_WAYS-1:0] hit_vec;
    logic [L1_WAY_W-1:0] hit_way;
    logic [L1_WAY_W-1:0] victim;
    logic [L1_WAY_W-1:0] way;
    logic hit;

    always_comb
    begin
        hit_way = '0;
        victim  = '0;
        for (int w = 0; w < L1_WAYS; w++)
        begin
            hit_vec[w] = row_reg.valid[w] && (row_reg.tag[w] == tag);
            if (row_reg.rank[w] == L1_WAY_W'(L1_WAYS - 1))
            begin
                victim = L1_WAY_W'(w);
            end
        end
        for (int w = L1_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = L1_WAY_W'(w);
            end
        end
        for (int w = L1_WAYS - 1; w >= 0; w--)
        begin
            if (!row_reg.valid[w])
            begin
                victim = L1_WAY_W'(w);
            end
        end
        hit = |hit_vec;
        way = hit ? hit_way : victim;

        new_row = row_reg;
        for (int w = 0; w < L1_WAYS; w++)
        begin
            if (row_reg.rank[w] < row_reg.rank[way])
            begin
                new_row.rank[w] = row_reg.rank[w] + 1'b1;
            end
        end
        new_row.rank[way]  = '0;
        new_row.tag[way]   = tag;
        new_row.valid[way] = 1'b1;
        new_row.dirty[way] = hit ? (row_reg.dirty[way] | set_dirty) : set_dirty;

        clr_row = '0;
        for (int w = 0; w < L1_WAYS; w++)
        begin
            clr_row.rank[w] = L1_WAY_W'(w);
        end

        res.hit   = hit;
        res.evict = !hit && row_reg.valid[victim] && row_reg.dirty[victim];
        res.vtag  = row_reg.tag[victim];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_reg <= mem[rd_idx];
            idx_reg <= rd_idx;
        end
        if (clr_en)
        begin
            mem[clr_idx] <= clr_row;
        end
        else if (commit)
        begin
            mem[idx_reg] <= new_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tlc_l2.sv
`default_nettype none

module tlc_l2
    import tlc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rd_en,
    input  wire logic [L2_SET_W-1:0] rd_idx,
    input  wire logic [L2_TAG_W-1:0] tag,
    input  wire logic                commit,
    input  wire logic                clr_en,
    input  wire logic [L2_SET_W-1:0] clr_idx,
    output logic                     hit
);

    l2_row_t mem [L2_SETS];
    l2_row_t row_reg;
    logic [L2_SET_W-1:0] idx_reg;

    l2_row_t new_row;
    l2_row_t clr_row;
    logic [L2_WAYS-1:0] hit_vec;
    logic [L2_WAY_W-1:0] hit_way;
    logic [L2_WAY_W-1:0] victim;
    logic [L2_WAY_W-1:0] way;

    always_comb
    begin
        hit_way = '0;
        victim  = '0;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            hit_vec[w] = row_reg.valid[w] && (row_reg.tag[w] == tag);
            if (row_reg.rank[w] == L2_WAY_W'(L2_WAYS - 1))
            begin
                victim = L2_WAY_W'(w);
            end
        end
        for (int w = L2_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = L2_WAY_W'(w);
            end
        end
        for (int w = L2_WAYS - 1; w >= 0; w--)
        begin
            if (!row_reg.valid[w])
            begin
                victim = L2_WAY_W'(w);
            end
        end
        hit = |hit_vec;
        way = hit ? hit_way : victim;

        new_row = row_reg;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            if (row_reg.rank[w] < row_reg.rank[way])
            begin
                new_row.rank[w] = row_reg.rank[w] + 1'b1;
            end
        end
        new_row.rank[way]  = '0;
        new_row.tag[way]   = tag;
        new_row.valid[way] = 1'b1;

        clr_row = '0;
        for (int w = 0; w < L2_WAYS; w++)
        begin
            clr_row.rank[w] = L2_WAY_W'(w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_reg <= mem[rd_idx];
            idx_reg <= rd_idx;
        end
        if (clr_en)
        begin
            mem[clr_idx] <= clr_row;
        end
        else if (commit)
        begin
            mem[idx_reg] <= new_row;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/two_level_cache_hit_model_top.sv
// Tag-only hit/miss model of split L1 instruction and data caches over a unified
// L2, all set-associative with LRU replacement. Each transfer on the input side
// gives one result transfer. After reset the block sweeps its tag memories, one
// L2 set per cycle, and stalls input meanwhile. An item goes through an L1
// lookup state; when L2 is looked up it adds an L2 read and an L2 write state,
// twice over when a dirty L1 victim is also written to L2: each L2 lookup is a
// read then a write-back of one set row of the L2 tag memory. write_back_mode
// is written through the cfg port, which is always ready.
`default_nettype none

module two_level_cache_hit_model_top
    import tlc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [ADDR_W-1:0] address,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   l1_hit,
    output logic                   l2_checked,
    output logic                   l2_hit,
    output logic                   dirty_evicted,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              write_back_mode
);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_L1   = 3'd2;
    localparam logic [2:0] ST_L2RD = 3'd3;
    localparam logic [2:0] ST_L2WR = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic wb_mode_reg;
    logic [1:0] op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [L2_LINE_W-1:0] l2line_reg, l2line_next;
    logic second_reg, second_next;
    logic r_l1_hit_reg, r_l1_hit_next;
    logic r_l2_chk_reg, r_l2_chk_next;
    logic r_l2_hit_reg, r_l2_hit_next;
    logic r_evict_reg, r_evict_next;
    logic out_valid_reg, out_valid_next;
    logic l1_hit_reg, l2_checked_reg, l2_hit_reg, evicted_reg;

    logic accept;
    logic load_out;
    logic [L1_IDX_W-1:0] l1_rd_idx;
    logic l1_rd_en, l1_commit, l1_clr, l2_rd_en, l2_commit, l2_clr, l2_hit_w;
    logic set_dirty;
    l1_res_t l1_res;
    logic [ADDR_W-1:0] vaddr;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign l1_rd_en  = accept;
    assign l1_rd_idx = {opcode != OP_FETCH, address[L1_OFF_W +: L1_SET_W]};
    assign l1_commit = (state_reg == ST_L1);
    assign set_dirty = (op_reg == OP_WRITE) && wb_mode_reg;
    assign l1_clr    = (state_reg == ST_CLR) && (clr_cnt_reg < CLR_W'(L1_ROWS));
    assign l2_rd_en  = (state_reg == ST_L2RD);
    assign l2_commit = (state_reg == ST_L2WR);
    assign l2_clr    = (state_reg == ST_CLR) && (clr_cnt_reg < CLR_W'(L2_SETS));
    assign vaddr     = {l1_res.vtag, addr_reg[L1_OFF_W +: L1_SET_W], {L1_OFF_W{1'b0}}};

    tlc_l1 u_l1 (
        .clk       (clk),
        .rd_en     (l1_rd_en),
        .rd_idx    (l1_rd_idx),
        .tag       (addr_reg[ADDR_W-1 -: L1_TAG_W]),
        .set_dirty (set_dirty),
        .commit    (l1_commit),
        .clr_en    (l1_clr),
        .clr_idx   (clr_cnt_reg[L1_IDX_W-1:0]),
        .res       (l1_res)
    );

    tlc_l2 u_l2 (
        .clk     (clk),
        .rd_en   (l2_rd_en),
        .rd_idx  (l2line_reg[L2_SET_W-1:0]),
        .tag     (l2line_reg[L2_LINE_W-1 -: L2_TAG_W]),
        .commit  (l2_commit),
        .clr_en  (l2_clr),
        .clr_idx (clr_cnt_reg[L2_SET_W-1:0]),
        .hit     (l2_hit_w)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        l2line_next    = l2line_reg;
        second_next    = second_reg;
        r_l1_hit_next  = r_l1_hit_reg;
        r_l2_chk_next  = r_l2_chk_reg;
        r_l2_hit_next  = r_l2_hit_reg;
        r_evict_next   = r_evict_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    r_l1_hit_next = 1'b0;
                    r_l2_chk_next = 1'b0;
                    r_l2_hit_next = 1'b0;
                    r_evict_next  = 1'b0;
                    state_next    = (opcode == OP_FETCH || opcode == OP_READ ||
                                     opcode == OP_WRITE) ? ST_L1 : ST_DONE;
                end
            end
            ST_L1:
            begin
                r_l1_hit_next = l1_res.hit;
                r_evict_next  = l1_res.evict;
                if (l1_res.hit && !((op_reg == OP_WRITE) && !wb_mode_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    r_l2_chk_next = 1'b1;
                    second_next   = l1_res.evict;
                    l2line_next   = l1_res.evict ? vaddr[ADDR_W-1:L2_OFF_W]
                                                 : addr_reg[ADDR_W-1:L2_OFF_W];
                    state_next    = ST_L2RD;
                end
            end
            ST_L2RD:
            begin
                state_next = ST_L2WR;
            end
            ST_L2WR:
            begin
                if (second_reg)
                begin
                    second_next = 1'b0;
                    l2line_next = addr_reg[ADDR_W-1:L2_OFF_W];
                    state_next  = ST_L2RD;
                end
                else
                begin
                    r_l2_hit_next = l2_hit_w;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            wb_mode_reg   <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                wb_mode_reg <= write_back_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
        end
        l2line_reg   <= l2line_next;
        r_l1_hit_reg <= r_l1_hit_next;
        r_l2_chk_reg <= r_l2_chk_next;
        r_l2_hit_reg <= r_l2_hit_next;
        r_evict_reg  <= r_evict_next;
        if (load_out)
        begin
            l1_hit_reg     <= r_l1_hit_reg;
            l2_checked_reg <= r_l2_chk_reg;
            l2_hit_reg     <= r_l2_hit_reg;
            evicted_reg    <= r_evict_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign l1_hit        = l1_hit_reg;
    assign l2_checked    = l2_checked_reg;
    assign l2_hit        = l2_hit_reg;
    assign dirty_evicted = evicted_reg;

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_L1 || state_reg == ST_DONE))
        else $error("accepted item did not start lookup");

    a_l2_hit_checked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (l2_checked || !l2_hit))
        else $error("l2_hit without l2 lookup");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dirty_evicted |-> !l1_hit && l2_checked)
        else $error("eviction reported on l1 hit");

    a_second_l2: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_L2WR) && second_reg |=> state_reg == ST_L2RD)
        else $error("victim write-back not followed by line lookup");

endmodule

`default_nettype wire

// File: sim/tb_two_level_cache_hit_model_top.sv
`default_nettype none

module tb_two_level_cache_hit_model_top;
    import tlc_pkg::*;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
    } access_t;

    typedef struct packed {
        logic l1_hit;
        logic l2_checked;
        logic l2_hit;
        logic dirty_evicted;
    } outcome_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic              out_valid;
    logic              out_stall;
    logic              l1_hit;
    logic              l2_checked;
    logic              l2_hit;
    logic              dirty_evicted;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              write_back_mode;

    two_level_cache_hit_model_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .address(address),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .l1_hit(l1_hit),
        .l2_checked(l2_checked),
        .l2_hit(l2_hit),
        .dirty_evicted(dirty_evicted),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .write_back_mode(write_back_mode)
    );

    // cache mirror
    logic [31:0] i_tag [L1_SETS][L1_WAYS];
    logic        i_vld [L1_SETS][L1_WAYS];
    int          i_rnk [L1_SETS][L1_WAYS];
    logic [31:0] d_tag [L1_SETS][L1_WAYS];
    logic        d_vld [L1_SETS][L1_WAYS];
    logic        d_drt [L1_SETS][L1_WAYS];
    int          d_rnk [L1_SETS][L1_WAYS];
    logic [31:0] u_tag [L2_SETS][L2_WAYS];
    logic        u_vld [L2_SETS][L2_WAYS];
    int          u_rnk [L2_SETS][L2_WAYS];
    logic        wb_mode;

    access_t  pending_q[$];
    outcome_t expected_q[$];
    int       errors;
    int       accepted_in;
    int       accepted_out;
    int       idle_cycles;
    int       n_hits, n_evicts;
    logic     quiet;
    logic     hold_in;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic bit l2_touch(logic [31:0] a);
        int s, w, v, old;
        logic [31:0] t;
        s = (a / L2_BLOCK_BYTES) % L2_SETS;
        t = (a / L2_BLOCK_BYTES) / L2_SETS;
        v = -1;
        for (w = 0; w < L2_WAYS; w++)
            if (v < 0 && u_vld[s][w] && u_tag[s][w] == t)
                v = w;
        l2_touch = (v >= 0);
        if (v < 0)
        begin
            for (w = L2_WAYS - 1; w >= 0; w--)
                if (u_rnk[s][w] == L2_WAYS - 1)
                    v = w;
            for (w = L2_WAYS - 1; w >= 0; w--)
                if (!u_vld[s][w])
                    v = w;
            u_tag[s][v] = t;
            u_vld[s][v] = 1;
        end
        old = u_rnk[s][v];
        for (w = 0; w < L2_WAYS; w++)
            if (u_rnk[s][w] < old)
                u_rnk[s][w]++;
        u_rnk[s][v] = 0;
    endfunction

    function automatic outcome_t predict_access(access_t a);
        outcome_t r;
        int s, w, v, old;
        logic [31:0] t;
        logic [63:0] va;
        bit data;
        r = '0;
        if (a.op == OP_FETCH || a.op == OP_READ || a.op == OP_WRITE)
        begin
            data = (a.op != OP_FETCH);
            s = (a.addr / L1_BLOCK_BYTES) % L1_SETS;
            t = (a.addr / L1_BLOCK_BYTES) / L1_SETS;
            v = -1;
            for (w = 0; w < L1_WAYS; w++)
                if (v < 0 && (data ? (d_vld[s][w] && d_tag[s][w] == t)
                                   : (i_vld[s][w] && i_tag[s][w] == t)))
                    v = w;
            if (v >= 0)
            begin
                r.l1_hit = 1;
                if (a.op == OP_WRITE)
                begin
                    if (wb_mode)
                        d_drt[s][v] = 1;
                    else
                    begin
                        r.l2_checked = 1;
                        r.l2_hit = l2_touch(a.addr);
                    end
                end
            end
            else
            begin
                for (w = L1_WAYS - 1; w >= 0; w--)
                    if ((data ? d_rnk[s][w] : i_rnk[s][w]) == L1_WAYS - 1)
                        v = w;
                for (w = L1_WAYS - 1; w >= 0; w--)
                    if (!(data ? d_vld[s][w] : i_vld[s][w]))
                        v = w;
                if (data && d_vld[s][v] && d_drt[s][v])
                begin
                    va = ((64'(d_tag[s][v]) * L1_SETS) + s) * L1_BLOCK_BYTES;
                    void'(l2_touch(va[31:0]));
                    r.dirty_evicted = 1;
                end
                r.l2_checked = 1;
                r.l2_hit = l2_touch(a.addr);
                if (data)
                begin
                    d_tag[s][v] = t;
                    d_vld[s][v] = 1;
                    d_drt[s][v] = (a.op == OP_WRITE) && wb_mode;
                end
                else
                begin
                    i_tag[s][v] = t;
                    i_vld[s][v] = 1;
                end
            end
            for (w = 0; w < L1_WAYS; w++)
            begin
                old = data ? d_rnk[s][v] : i_rnk[s][v];
                if (data && d_rnk[s][w] < old)
                    d_rnk[s][w]++;
                if (!data && i_rnk[s][w] < old)
                    i_rnk[s][w]++;
            end
            if (data)
                d_rnk[s][v] = 0;
            else
                i_rnk[s][v] = 0;
        end
        return r;
    endfunction

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 21);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            opcode   <= '0;
            address  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(predict_access('{opcode, address}));
                accepted_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && !hold_in && !idle_roll())
                begin
                    in_valid <= 1;
                    opcode   <= pending_q[0].op;
                    address  <= pending_q[0].addr;
                    void'(pending_q.pop_front());
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e, got;
        if (!rst_n)
            out_stall <= 0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{l1_hit, l2_checked, l2_hit, dirty_evicted};
                accepted_out++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %b", $time, got);
                end
                else
                begin
                    e = expected_q.pop_front();
                    n_hits += e.l1_hit;
                    n_evicts += e.dirty_evicted;
                    if (e.l1_hit !== got.l1_hit)
                        $display("%0t: l1_hit exp %b got %b", $time, e.l1_hit, got.l1_hit);
                    if (e.l2_checked !== got.l2_checked)
                        $display("%0t: l2_checked exp %b got %b", $time,
                                 e.l2_checked, got.l2_checked);
                    if (e.l2_hit !== got.l2_hit)
                        $display("%0t: l2_hit exp %b got %b", $time, e.l2_hit, got.l2_hit);
                    if (e.dirty_evicted !== got.dirty_evicted)
                        $display("%0t: dirty_evicted exp %b got %b", $time,
                                 e.dirty_evicted, got.dirty_evicted);
                    if (e !== got)
                        errors++;
                end
            end
            out_stall <= idle_roll();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        @(posedge clk);
        cfg_valid       <= 1;
        write_back_mode <= m;
        do @(posedge clk); while (!cfg_ready);
        wb_mode = m;
        cfg_valid <= 0;
    endtask

    // hot addresses: few tags per set so L1 and L2 conflicts are common
    function automatic logic [31:0] hot_addr();
        logic [31:0] a;
        a = '0;
        a[4:0]   = 5'($urandom);
        a[6:5]   = 2'($urandom);
        a[12:11] = 2'($urandom);
        a[17:15] = 3'($urandom_range(7));
        return a;
    endfunction

    function automatic access_t rand_access(bit noise);
        access_t a;
        a.op   = noise ? 2'($urandom) : 2'($urandom_range(2));
        a.addr = noise ? $urandom : hot_addr();
        return a;
    endfunction

    initial
    begin
        int k, ph;
        errors = 0; accepted_in = 0; accepted_out = 0; idle_cycles = 0;
        n_hits = 0; n_evicts = 0; quiet = 0; hold_in = 1;
        rst_n = 0; cfg_valid = 0; write_back_mode = 0;
        in_valid = 0; opcode = '0; address = '0; out_stall = 0;
        wb_mode = 0;
        for (int s = 0; s < L1_SETS; s++)
            for (int w = 0; w < L1_WAYS; w++)
            begin
                i_vld[s][w] = 0; i_rnk[s][w] = w; i_tag[s][w] = '0;
                d_vld[s][w] = 0; d_drt[s][w] = 0; d_rnk[s][w] = w; d_tag[s][w] = '0;
            end
        for (int s = 0; s < L2_SETS; s++)
            for (int w = 0; w < L2_WAYS; w++)
            begin
                u_vld[s][w] = 0; u_rnk[s][w] = w; u_tag[s][w] = '0;
            end
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed: write-through, then write-back with dirty evictions, then write-through again
        set_mode(0);
        pending_q.push_back('{OP_FETCH, 32'h0000_0000});
        pending_q.push_back('{OP_FETCH, 32'h0000_0000});
        pending_q.push_back('{OP_FETCH, 32'hFFFF_FFFF});
        pending_q.push_back('{OP_READ,  32'hFFFF_FFFF});
        pending_q.push_back('{OP_WRITE, 32'hFFFF_FFE0});
        pending_q.push_back('{OP_WRITE, 32'h0000_0040});
        pending_q.push_back('{2'd3,     32'h1234_5678});
        pending_q.push_back('{OP_READ,  32'h0000_0040});
        hold_in = 0;
        drain();
        hold_in = 1;
        set_mode(1);
        pending_q.push_back('{OP_WRITE, 32'h0000_0800});
        pending_q.push_back('{OP_WRITE, 32'h0000_1000});
        pending_q.push_back('{OP_WRITE, 32'h0000_0800});
        pending_q.push_back('{OP_READ,  32'h0000_1800});
        pending_q.push_back('{OP_READ,  32'h0000_2000});
        pending_q.push_back('{OP_WRITE, 32'hAAAA_AAA0});
        pending_q.push_back('{OP_WRITE, 32'h5555_5540});
        pending_q.push_back('{2'd3,     32'hFFFF_FFFF});
        hold_in = 0;
        drain();
        hold_in = 1;
        set_mode(0);
        pending_q.push_back('{OP_WRITE, 32'hAAAA_AAA0});
        pending_q.push_back('{OP_READ,  32'h0000_3800});
        pending_q.push_back('{OP_READ,  32'h0000_4800});
        hold_in = 0;
        drain();

        // random phases, alternating policy
        for (ph = 0; ph < 4; ph++)
        begin
            hold_in = 1;
            set_mode(ph[0] ? 0 : 1);
            quiet = (ph == 2);
            for (k = 0; k < 200; k++)
                pending_q.push_back(rand_access($urandom_range(9) == 0));
            hold_in = 0;
            drain();
        end
        quiet = 0;

        $display("Covered %0d accesses (%0d results), %0d L1 hits, %0d dirty victims,",
                 accepted_in, accepted_out, n_hits, n_evicts);
        $display("both write policies with stalls on both sides.");
        if (errors == 0 && expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
